// ===== src/dkphq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the destination-keyed packet hold queue.
// No dependencies.
package dkphq_pkg;

   localparam int DEPTH = 32;
   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = 6;
   localparam int DEST_BITS = 32;
   localparam int HANDLE_BITS = 16;
   localparam int MAX_ENTRIES_RESET = 32;
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_BITS = $clog2(CMDQ_DEPTH);

   typedef enum logic [2:0] {
      MODE_ENQUEUE = 3'd0,
      MODE_FIND    = 3'd1,
      MODE_DROP    = 3'd2,
      MODE_SEND    = 3'd3,
      MODE_FLUSH   = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      KIND_ENQUEUED = 3'd0,
      KIND_REJECTED = 3'd1,
      KIND_FIND     = 3'd2,
      KIND_RELEASED = 3'd3,
      KIND_NONE     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      OP_ENQ,
      OP_FIND,
      OP_RELEASE,
      OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [2:0]             mode;
      logic [DEST_BITS-1:0]   dest_addr;
      logic [HANDLE_BITS-1:0] packet_handle;
   } req_word_type;

   typedef struct packed {
      logic [2:0]             kind;
      logic                   found;
      logic [HANDLE_BITS-1:0] released_handle;
      logic [DEST_BITS-1:0]   released_dest;
      logic                   send_action;
      logic                   notify_unreachable;
      logic [CNT_BITS-1:0]    release_count;
      logic                   last;
      logic [CNT_BITS-1:0]    queue_length;
   } rsp_word_type;

   typedef struct packed {
      op_type                 op;
      logic                   match_all;
      logic                   send;
      logic                   drop;
      logic [DEST_BITS-1:0]   dest;
      logic [HANDLE_BITS-1:0] handle;
   } cmd_type;

   typedef struct packed {
      logic [DEST_BITS-1:0]   dest;
      logic [HANDLE_BITS-1:0] handle;
   } entry_type;

endpackage

// ===== src/dkphq_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts request words and decodes them into commands.
// Depends on dkphq_pkg.
module dkphq_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dkphq_pkg::req_word_type req_word,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output dkphq_pkg::cmd_type    cmd_word
);
   import dkphq_pkg::*;

   logic    cmd_valid_ff;
   cmd_type cmd_ff;
   cmd_type cmd_in;

   always_comb begin
      cmd_in           = '0;
      cmd_in.dest      = req_word.dest_addr;
      cmd_in.handle    = req_word.packet_handle;
      unique case (req_word.mode)
         MODE_ENQUEUE: cmd_in.op = OP_ENQ;
         MODE_FIND:    cmd_in.op = OP_FIND;
         MODE_DROP: begin
            cmd_in.op   = OP_RELEASE;
            cmd_in.drop = 1'b1;
         end
         MODE_SEND: begin
            cmd_in.op   = OP_RELEASE;
            cmd_in.send = 1'b1;
         end
         MODE_FLUSH: begin
            cmd_in.op        = OP_RELEASE;
            cmd_in.match_all = 1'b1;
         end
         default: cmd_in.op = OP_NOP;
      endcase
   end

   assign req_ready = !cmd_valid_ff || cmd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else if (req_ready) begin
         cmd_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd_word  = cmd_ff;

endmodule

// ===== src/dkphq_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Depends on dkphq_pkg.
module dkphq_cmd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  dkphq_pkg::cmd_type push_word,
   output logic               pop_valid,
   input  logic               pop_ready,
   output dkphq_pkg::cmd_type pop_word
);
   import dkphq_pkg::*;

   cmd_type                  slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_BITS-1:0] wr_ptr_ff;
   logic [CMDQ_PTR_BITS-1:0] rd_ptr_ff;
   logic [CMDQ_PTR_BITS:0]   fill_ff;
   logic                     push;
   logic                     pop;

   assign push_ready = fill_ff != (CMDQ_PTR_BITS+1)'(CMDQ_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_word   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== src/dkphq_back.sv =====
`timescale 1ns / 1ps
// Back end: entry store, scan and compaction sequencer, result register.
// Depends on dkphq_pkg.
module dkphq_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  dkphq_pkg::cmd_type            cmd_word,
   input  logic                          csr_wr_en,
   input  logic [dkphq_pkg::CNT_BITS-1:0] csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dkphq_pkg::rsp_word_type       rsp_word
);
   import dkphq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;
   logic [IDX_BITS-1:0] rd_addr;
   logic                wr_en;
   logic [IDX_BITS-1:0] wr_addr;
   entry_type           wr_data;

   state_type           state_ff, state_in;
   cmd_type             cur_ff, cur_in;
   logic [IDX_BITS-1:0] i_ff, i_in;
   logic [IDX_BITS-1:0] keep_ff, keep_in;
   logic [CNT_BITS-1:0] n_ff, n_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] rel_cnt_ff, rel_cnt_in;
   logic                found_ff, found_in;
   logic                pend_v_ff, pend_v_in;
   rsp_word_type        pend_ff, pend_in;
   logic [CNT_BITS-1:0] max_entries_ff;
   logic                rsp_valid_ff;
   rsp_word_type        rsp_word_ff;
   logic                rsp_load;
   rsp_word_type        rsp_next;

   logic                out_free;
   logic [CNT_BITS-1:0] limit;
   logic                match;
   logic                last_idx;
   logic                advance;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign limit    = (max_entries_ff > CNT_BITS'(DEPTH)) ? CNT_BITS'(DEPTH) : max_entries_ff;
   assign match    = cur_ff.match_all || (rd_data_ff.dest == cur_ff.dest);
   assign last_idx = CNT_BITS'(i_ff) == (n_ff - CNT_BITS'(1));

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      i_in       = i_ff;
      keep_in    = keep_ff;
      n_in       = n_ff;
      count_in   = count_ff;
      rel_cnt_in = rel_cnt_ff;
      found_in   = found_ff;
      pend_v_in  = pend_v_ff;
      pend_in    = pend_ff;
      cmd_ready  = 1'b0;
      rsp_load   = 1'b0;
      rsp_next   = '0;
      wr_en      = 1'b0;
      wr_addr    = count_ff[IDX_BITS-1:0];
      wr_data    = '{dest: cmd_word.dest, handle: cmd_word.handle};
      rd_addr    = '0;
      advance    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_word.op)
                  OP_ENQ: begin
                     if (out_free) begin
                        cmd_ready                = 1'b1;
                        rsp_load                 = 1'b1;
                        rsp_next.released_dest   = cmd_word.dest;
                        rsp_next.released_handle = cmd_word.handle;
                        rsp_next.last            = 1'b1;
                        if (count_ff >= limit) begin
                           rsp_next.kind         = KIND_REJECTED;
                           rsp_next.queue_length = count_ff;
                        end else begin
                           wr_en                 = 1'b1;
                           count_in              = count_ff + 1'b1;
                           rsp_next.kind         = KIND_ENQUEUED;
                           rsp_next.queue_length = count_ff + 1'b1;
                        end
                     end
                  end
                  OP_FIND, OP_RELEASE: begin
                     cmd_ready  = 1'b1;
                     cur_in     = cmd_word;
                     i_in       = '0;
                     keep_in    = '0;
                     n_in       = count_ff;
                     rel_cnt_in = '0;
                     found_in   = 1'b0;
                     pend_v_in  = 1'b0;
                     state_in   = (count_ff == '0) ? ST_FIN : ST_SCAN;
                  end
                  default: begin
                     if (out_free) begin
                        cmd_ready              = 1'b1;
                        rsp_load               = 1'b1;
                        rsp_next.kind          = KIND_NONE;
                        rsp_next.released_dest = cmd_word.dest;
                        rsp_next.last          = 1'b1;
                        rsp_next.queue_length  = count_ff;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // a new match pushes out the held result, which needs the output slot
            advance = !(cur_ff.op == OP_RELEASE && match && pend_v_ff && !out_free);
            if (advance) begin
               if (cur_ff.op == OP_FIND) begin
                  found_in = found_ff | match;
               end else if (match) begin
                  if (pend_v_ff) begin
                     rsp_load = 1'b1;
                     rsp_next = pend_ff;
                  end
                  pend_v_in                  = 1'b1;
                  pend_in                    = '0;
                  pend_in.kind               = KIND_RELEASED;
                  pend_in.released_handle    = rd_data_ff.handle;
                  pend_in.released_dest      = rd_data_ff.dest;
                  pend_in.send_action        = cur_ff.send;
                  pend_in.notify_unreachable = cur_ff.drop && (rel_cnt_ff == '0);
                  pend_in.release_count      = rel_cnt_ff + 1'b1;
                  pend_in.queue_length       = count_ff - 1'b1;
                  count_in                   = count_ff - 1'b1;
                  rel_cnt_in                 = rel_cnt_ff + 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = keep_ff;
                  wr_data = rd_data_ff;
                  keep_in = keep_ff + 1'b1;
               end
               if (last_idx) begin
                  state_in = ST_FIN;
               end else begin
                  i_in = i_ff + 1'b1;
               end
               rd_addr = i_ff + 1'b1;
            end else begin
               rd_addr = i_ff;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (cur_ff.op == OP_FIND) begin
                  rsp_next.kind          = KIND_FIND;
                  rsp_next.found         = found_ff;
                  rsp_next.released_dest = cur_ff.dest;
                  rsp_next.last          = 1'b1;
                  rsp_next.queue_length  = count_ff;
               end else if (pend_v_ff) begin
                  rsp_next      = pend_ff;
                  rsp_next.last = 1'b1;
                  pend_v_in     = 1'b0;
               end else begin
                  rsp_next.kind          = KIND_NONE;
                  rsp_next.released_dest = cur_ff.dest;
                  rsp_next.send_action   = cur_ff.send;
                  rsp_next.last          = 1'b1;
                  rsp_next.queue_length  = count_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         pend_v_ff      <= 1'b0;
         max_entries_ff <= CNT_BITS'(MAX_ENTRIES_RESET);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_v_ff <= pend_v_in;
         if (csr_wr_en) begin
            max_entries_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      i_ff       <= i_in;
      keep_ff    <= keep_in;
      n_ff       <= n_in;
      rel_cnt_ff <= rel_cnt_in;
      found_ff   <= found_in;
      pend_ff    <= pend_in;
      if (rsp_load) begin
         rsp_word_ff <= rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== src/dest_keyed_packet_hold_queue.sv =====
`timescale 1ns / 1ps
// Enqueue and unknown-mode words: result registered in the front end, command queue and
// result register; one word per cycle sustained while the output is not stalled.
// Find, drop, send, flush: the entry store scan sets the rate, one entry per cycle unless a
// match waits on a stalled output; released words leave one per cycle if it is not stalled.
// Synchronous active-high reset empties the queue and sets max_entries to 32.
// Top level of the hold queue; depends on dkphq_pkg, dkphq_front, dkphq_cmd_fifo, dkphq_back.
module dest_keyed_packet_hold_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  dkphq_pkg::req_word_type        req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output dkphq_pkg::rsp_word_type        rsp_word,
   input  logic                           csr_wr_en,
   input  logic [dkphq_pkg::CNT_BITS-1:0] csr_wr_data
);
   import dkphq_pkg::*;

   logic    f_valid, f_ready;
   cmd_type f_word;
   logic    q_valid, q_ready;
   cmd_type q_word;

   dkphq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd_word  (f_word)
   );

   dkphq_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_word  (f_word),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_word   (q_word)
   );

   dkphq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (q_valid),
      .cmd_ready   (q_ready),
      .cmd_word    (q_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench of dest_keyed_packet_hold_queue: a directed table, then random phases under several
// queue limits, each response checked against an in-bench model of the hold queue.
// Depends on dkphq_pkg and the block's RTL.
module tb;
   import dkphq_pkg::*;

   typedef struct {
      bit           set_cfg;
      int           cfg;
      req_word_type w;
      bit           typed;
      rsp_word_type want;
   } plan_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_word_type        req_word = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_word_type        rsp_word;
   logic                csr_wr_en = 1'b0;
   logic [CNT_BITS-1:0] csr_wr_data = '0;

   logic [DEST_BITS-1:0]   held_dest [DEPTH];
   logic [HANDLE_BITS-1:0] held_handle [DEPTH];
   int                     held_count = 0;
   int                     max_entries_reg = MAX_ENTRIES_RESET;
   rsp_word_type           due_words [$];
   plan_row_type           plan_rows [$];
   logic [DEST_BITS-1:0]   dest_pool [4];
   int                     phase_limits [10] = '{32, 63, 5, 0, 33, 1, 31, 40, 2, 32};
   int                     mismatches = 0;
   bit                     calm = 1'b0;
   bit                     hold_rsp = 1'b0;

   dest_keyed_packet_hold_queue u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_word_type make_rsp(kind_type kind, logic found,
                                             logic [HANDLE_BITS-1:0] handle,
                                             logic [DEST_BITS-1:0] dest, logic act, logic note,
                                             int cnt, logic last, int qlen);
      rsp_word_type r;
      r.kind               = kind;
      r.found              = found;
      r.released_handle    = handle;
      r.released_dest      = dest;
      r.send_action        = act;
      r.notify_unreachable = note;
      r.release_count      = cnt[CNT_BITS-1:0];
      r.last               = last;
      r.queue_length       = qlen[CNT_BITS-1:0];
      return r;
   endfunction

   function automatic string show(rsp_word_type r);
      return $sformatf("kind %0d found %0d handle %h dest %h send %0d note %0d cnt %0d last %0d len %0d",
                       r.kind, r.found, r.released_handle, r.released_dest, r.send_action,
                       r.notify_unreachable, r.release_count, r.last, r.queue_length);
   endfunction

   // Applies one accepted word to the held entries and queues the response words it causes.
   function automatic void hold_queue_step(req_word_type w);
      int                     lim, keep, k, hits, n, i;
      logic [DEST_BITS-1:0]   d;
      logic [HANDLE_BITS-1:0] h;
      bit                     all_match, act, drop, found;
      lim = (max_entries_reg > DEPTH) ? DEPTH : max_entries_reg;
      all_match = (w.mode == MODE_FLUSH);
      act = (w.mode == MODE_SEND);
      drop = (w.mode == MODE_DROP);
      unique case (w.mode)
         MODE_ENQUEUE: begin
            if (held_count >= lim) begin
               due_words.push_back(make_rsp(KIND_REJECTED, 1'b0, w.packet_handle, w.dest_addr,
                                            1'b0, 1'b0, 0, 1'b1, held_count));
            end else begin
               held_dest[held_count] = w.dest_addr;
               held_handle[held_count] = w.packet_handle;
               held_count++;
               due_words.push_back(make_rsp(KIND_ENQUEUED, 1'b0, w.packet_handle, w.dest_addr,
                                            1'b0, 1'b0, 0, 1'b1, held_count));
            end
         end
         MODE_FIND: begin
            found = 1'b0;
            for (i = 0; i < held_count; i++)
               if (held_dest[i] == w.dest_addr) found = 1'b1;
            due_words.push_back(make_rsp(KIND_FIND, found, '0, w.dest_addr, 1'b0, 1'b0, 0, 1'b1,
                                         held_count));
         end
         MODE_DROP, MODE_SEND, MODE_FLUSH: begin
            hits = 0;
            for (i = 0; i < held_count; i++)
               if (all_match || held_dest[i] == w.dest_addr) hits++;
            keep = 0;
            k = 0;
            n = held_count;
            for (i = 0; i < n; i++) begin
               d = held_dest[i];
               h = held_handle[i];
               if (all_match || d == w.dest_addr) begin
                  held_count--;
                  k++;
                  due_words.push_back(make_rsp(KIND_RELEASED, 1'b0, h, d, act, drop && k == 1,
                                               k, k == hits, held_count));
               end else begin
                  held_dest[keep] = d;
                  held_handle[keep] = h;
                  keep++;
               end
            end
            if (hits == 0)
               due_words.push_back(make_rsp(KIND_NONE, 1'b0, '0, w.dest_addr, act, 1'b0, 0,
                                            1'b1, held_count));
         end
         default: begin
            due_words.push_back(make_rsp(KIND_NONE, 1'b0, '0, w.dest_addr, 1'b0, 1'b0, 0, 1'b1,
                                         held_count));
         end
      endcase
   endfunction

   function automatic void check_rsp(rsp_word_type got);
      rsp_word_type want;
      if (due_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response word: %s", show(got));
         return;
      end
      want = due_words.pop_front();
      if (got.kind !== want.kind || got.found !== want.found ||
          got.released_handle !== want.released_handle ||
          got.released_dest !== want.released_dest || got.send_action !== want.send_action ||
          got.notify_unreachable !== want.notify_unreachable ||
          got.release_count !== want.release_count || got.last !== want.last ||
          got.queue_length !== want.queue_length) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("response mismatch, expected: %s", show(want));
            $display("                   actual:   %s", show(got));
         end
      end
   endfunction

   function automatic void add_row(bit set_cfg, int cfg, logic [2:0] mode,
                                   logic [DEST_BITS-1:0] dest, logic [HANDLE_BITS-1:0] handle,
                                   bit typed, rsp_word_type want);
      plan_row_type row;
      row.set_cfg = set_cfg;
      row.cfg = cfg;
      row.w.mode = mode;
      row.w.dest_addr = dest;
      row.w.packet_handle = handle;
      row.typed = typed;
      row.want = want;
      plan_rows.push_back(row);
   endfunction

   task automatic set_max_entries(input int value);
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[CNT_BITS-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      max_entries_reg = value;
   endtask

   task automatic drive_req(input req_word_type w, input bit typed, input rsp_word_type want);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      hold_queue_step(w);
      // typed rows cause a single word; the typed one replaces the computed one
      if (typed) due_words[due_words.size() - 1] = want;
   endtask

   initial begin
      int gap;
      wait (reset == 1'b0);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
         end
         gap = calm ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         check_rsp(rsp_word);
      end
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      plan_row_type row;
      req_word_type w;
      int           r, enq_pct, n_items;
      add_row(1'b0, 0, MODE_FIND, 32'h0, 16'h0, 1'b1,
              make_rsp(KIND_FIND, 1'b0, 16'h0, 32'h0, 1'b0, 1'b0, 0, 1'b1, 0));
      add_row(1'b0, 0, MODE_DROP, 32'hFFFFFFFF, 16'h0, 1'b1,
              make_rsp(KIND_NONE, 1'b0, 16'h0, 32'hFFFFFFFF, 1'b0, 1'b0, 0, 1'b1, 0));
      add_row(1'b0, 0, MODE_SEND, 32'h0, 16'h0, 1'b1,
              make_rsp(KIND_NONE, 1'b0, 16'h0, 32'h0, 1'b1, 1'b0, 0, 1'b1, 0));
      add_row(1'b0, 0, MODE_FLUSH, 32'h12345678, 16'h0, 1'b1,
              make_rsp(KIND_NONE, 1'b0, 16'h0, 32'h12345678, 1'b0, 1'b0, 0, 1'b1, 0));
      add_row(1'b0, 0, 3'd5, 32'h80000001, 16'hFFFF, 1'b1,
              make_rsp(KIND_NONE, 1'b0, 16'h0, 32'h80000001, 1'b0, 1'b0, 0, 1'b1, 0));
      add_row(1'b0, 0, 3'd7, 32'h0, 16'h0001, 1'b1,
              make_rsp(KIND_NONE, 1'b0, 16'h0, 32'h0, 1'b0, 1'b0, 0, 1'b1, 0));
      add_row(1'b0, 0, MODE_ENQUEUE, 32'hFFFFFFFF, 16'hFFFF, 1'b1,
              make_rsp(KIND_ENQUEUED, 1'b0, 16'hFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, 0, 1'b1, 1));
      add_row(1'b0, 0, MODE_ENQUEUE, 32'h0, 16'h0, 1'b1,
              make_rsp(KIND_ENQUEUED, 1'b0, 16'h0, 32'h0, 1'b0, 1'b0, 0, 1'b1, 2));
      add_row(1'b0, 0, MODE_ENQUEUE, 32'hFFFFFFFF, 16'h1234, 1'b1,
              make_rsp(KIND_ENQUEUED, 1'b0, 16'h1234, 32'hFFFFFFFF, 1'b0, 1'b0, 0, 1'b1, 3));
      add_row(1'b0, 0, MODE_ENQUEUE, 32'h0A000001, 16'h5555, 1'b1,
              make_rsp(KIND_ENQUEUED, 1'b0, 16'h5555, 32'h0A000001, 1'b0, 1'b0, 0, 1'b1, 4));
      add_row(1'b0, 0, MODE_FIND, 32'hFFFFFFFF, 16'h0, 1'b1,
              make_rsp(KIND_FIND, 1'b1, 16'h0, 32'hFFFFFFFF, 1'b0, 1'b0, 0, 1'b1, 4));
      add_row(1'b0, 0, MODE_FIND, 32'h00000001, 16'h0, 1'b1,
              make_rsp(KIND_FIND, 1'b0, 16'h0, 32'h00000001, 1'b0, 1'b0, 0, 1'b1, 4));
      add_row(1'b0, 0, MODE_DROP, 32'hFFFFFFFF, 16'h0, 1'b0, '0);
      add_row(1'b0, 0, MODE_SEND, 32'h0, 16'h0, 1'b0, '0);
      add_row(1'b0, 0, MODE_ENQUEUE, 32'h0A000002, 16'h0001, 1'b0, '0);
      add_row(1'b0, 0, MODE_FLUSH, 32'h0, 16'h0, 1'b0, '0);
      add_row(1'b1, 0, MODE_ENQUEUE, 32'h00000001, 16'h0002, 1'b1,
              make_rsp(KIND_REJECTED, 1'b0, 16'h0002, 32'h00000001, 1'b0, 1'b0, 0, 1'b1, 0));
      add_row(1'b1, 1, MODE_ENQUEUE, 32'hC0A80001, 16'h7777, 1'b1,
              make_rsp(KIND_ENQUEUED, 1'b0, 16'h7777, 32'hC0A80001, 1'b0, 1'b0, 0, 1'b1, 1));
      add_row(1'b0, 0, MODE_ENQUEUE, 32'hC0A80001, 16'h8888, 1'b1,
              make_rsp(KIND_REJECTED, 1'b0, 16'h8888, 32'hC0A80001, 1'b0, 1'b0, 0, 1'b1, 1));
      add_row(1'b1, 63, MODE_ENQUEUE, 32'hC0A80001, 16'h9999, 1'b0, '0);
      add_row(1'b0, 0, MODE_SEND, 32'hC0A80001, 16'h0, 1'b0, '0);
      add_row(1'b0, 0, 3'd6, 32'hFFFFFFFF, 16'hAAAA, 1'b1,
              make_rsp(KIND_NONE, 1'b0, 16'h0, 32'hFFFFFFFF, 1'b0, 1'b0, 0, 1'b1, 0));
      phase_limits[9] = $urandom_range(0, 63);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_rows[i]) begin
         row = plan_rows[i];
         if (row.set_cfg) set_max_entries(row.cfg);
         drive_req(row.w, row.typed, row.want);
      end

      for (int p = 0; p < 10; p++) begin
         set_max_entries(phase_limits[p]);
         calm = (p % 3 == 2);
         enq_pct = (p == 1) ? 92 : ((p % 2 == 1) ? 70 : 45);
         n_items = (p == 1) ? 46 : 36;
         foreach (dest_pool[j]) dest_pool[j] = $urandom;
         // long receiver stall while the queue fills
         if (p == 1) hold_rsp = 1'b1;
         repeat (n_items) begin
            w.dest_addr = ($urandom_range(0, 99) < 85) ? dest_pool[$urandom_range(0, 3)]
                                                      : $urandom;
            w.packet_handle = 16'($urandom_range(0, 65535));
            r = $urandom_range(0, 99);
            if (r < enq_pct) begin
               w.mode = MODE_ENQUEUE;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 30) w.mode = MODE_FIND;
               else if (r < 55) w.mode = MODE_DROP;
               else if (r < 80) w.mode = MODE_SEND;
               else if (r < 90) w.mode = MODE_FLUSH;
               else w.mode = 3'($urandom_range(5, 7));
            end
            drive_req(w, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== dest_keyed_packet_hold_queue.f =====
src/dkphq_pkg.sv
src/dkphq_front.sv
src/dkphq_cmd_fifo.sv
src/dkphq_back.sv
src/dest_keyed_packet_hold_queue.sv
tb/tb.sv
